[hdl/dsb_pkg.sv]
// ----------------------------------------------------------------------------
// dsb_pkg
// Shared types and codes for the dual-stack bundle processor core.
// ----------------------------------------------------------------------------
`default_nettype none

package dsb_pkg;

  // Host commands after classification by the front end.
  typedef enum logic [2:0] {
    CMD_WRITE = 3'd0,
    CMD_READ  = 3'd1,
    CMD_PUSH  = 3'd2,
    CMD_POP   = 3'd3,
    CMD_START = 3'd4,
    CMD_STEP  = 3'd5,
    CMD_NONE  = 3'd7
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] addr;
    logic [31:0] value;
  } req_t;

  // Result status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_HALT    = 3'd1;
  localparam logic [2:0] ST_IOQ     = 3'd2;
  localparam logic [2:0] ST_IOI     = 3'd3;
  localparam logic [2:0] ST_INVALID = 3'd4;
  localparam logic [2:0] ST_DIVZ    = 3'd5;

  // Opcodes of one bundle slot.
  localparam logic [4:0] OPC_NOP   = 5'd0;
  localparam logic [4:0] OPC_LIT   = 5'd1;
  localparam logic [4:0] OPC_DUP   = 5'd2;
  localparam logic [4:0] OPC_DROP  = 5'd3;
  localparam logic [4:0] OPC_SWAP  = 5'd4;
  localparam logic [4:0] OPC_PUSH  = 5'd5;
  localparam logic [4:0] OPC_POP   = 5'd6;
  localparam logic [4:0] OPC_JUMP  = 5'd7;
  localparam logic [4:0] OPC_CALL  = 5'd8;
  localparam logic [4:0] OPC_CCALL = 5'd9;
  localparam logic [4:0] OPC_RET   = 5'd10;
  localparam logic [4:0] OPC_EQ    = 5'd11;
  localparam logic [4:0] OPC_NE    = 5'd12;
  localparam logic [4:0] OPC_LT    = 5'd13;
  localparam logic [4:0] OPC_GT    = 5'd14;
  localparam logic [4:0] OPC_FETCH = 5'd15;
  localparam logic [4:0] OPC_STORE = 5'd16;
  localparam logic [4:0] OPC_ADD   = 5'd17;
  localparam logic [4:0] OPC_SUB   = 5'd18;
  localparam logic [4:0] OPC_MUL   = 5'd19;
  localparam logic [4:0] OPC_DIV   = 5'd20;
  localparam logic [4:0] OPC_AND   = 5'd21;
  localparam logic [4:0] OPC_OR    = 5'd22;
  localparam logic [4:0] OPC_XOR   = 5'd23;
  localparam logic [4:0] OPC_SHIFT = 5'd24;
  localparam logic [4:0] OPC_ZRET  = 5'd25;
  localparam logic [4:0] OPC_HALT  = 5'd26;
  localparam logic [4:0] OPC_ENUM  = 5'd27;
  localparam logic [4:0] OPC_IOQ   = 5'd28;
  localparam logic [4:0] OPC_IOI   = 5'd29;

  localparam logic [7:0] OPC_LAST  = 8'd29;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [31:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

[hdl/dual_stack_bundle_cpu_top.sv]
// ----------------------------------------------------------------------------
// dual_stack_bundle_cpu_top
// Dual-stack bundle processor core: front end queue, execution back end and
// iterative divider.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  in      | in_valid / in_ready  | op, addr, value
//  out     | out_valid / out_ready| status, read_value, pc_now, data_depth,
//          |                      | return_depth, device_id
//  cfg     | cfg_we               | cfg_wdata (device count)
//
// A host request passes S_IDLE, S_HOST, S_FRD and S_FOUT; a read adds S_HWAIT.
// A step fetches its bundle in S_HWAIT, then runs each opcode slot through
// S_RD, S_EX, S_WR1, S_WR2 and S_NEXT, with S_MEM for lit and memory fetch and
// S_DIV for divide; the sequencer runs one opcode at a time. After reset, a
// clearing pass zeroes both stacks while in_ready is low. The two-entry request
// queue and the result register absorb a short stall on either side.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_stack_bundle_cpu_top #(
  parameter int MEM_WORDS  = 65536,
  parameter int DATA_DEPTH = 256,
  parameter int RET_DEPTH  = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  op,
  input  wire logic [15:0] addr,
  input  wire logic [31:0] value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [31:0]      read_value,
  output logic [16:0]      pc_now,
  output logic [7:0]       data_depth,
  output logic [7:0]       return_depth,
  output logic [4:0]       device_id,
  input  wire logic        cfg_we,
  input  wire logic [5:0]  cfg_wdata
);

  dsb_pkg::req_t     head;
  logic              head_valid;
  logic              pop;
  logic              clearing;
  dsb_pkg::div_req_t dreq;
  dsb_pkg::div_rsp_t drsp;

  dsb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .addr       (addr),
    .value      (value),
    .block      (clearing),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  dsb_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  dsb_exec #(
    .MEM_WORDS  (MEM_WORDS),
    .DATA_DEPTH (DATA_DEPTH),
    .RET_DEPTH  (RET_DEPTH)
  ) u_exec (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .clearing     (clearing),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .dreq         (dreq),
    .drsp         (drsp),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .read_value   (read_value),
    .pc_now       (pc_now),
    .data_depth   (data_depth),
    .return_depth (return_depth),
    .device_id    (device_id)
  );

endmodule

`default_nettype wire

[hdl/dsb_front.sv]
// ----------------------------------------------------------------------------
// dsb_front
// Request front end: accepts host requests, classifies the operation and
// holds them in a two-entry queue for the execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dsb_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [2:0]    op,
  input  wire logic [15:0]   addr,
  input  wire logic [31:0]   value,
  input  wire logic          block,
  output dsb_pkg::req_t      head,
  output logic               head_valid,
  input  wire logic          pop
);

  dsb_pkg::req_t q [2];
  logic [1:0]    count;
  logic          wr_ptr;
  logic          rd_ptr;
  dsb_pkg::cmd_t cmd;
  logic          push;

  always_comb begin
    case (op)
      3'd0:    cmd = dsb_pkg::CMD_WRITE;
      3'd1:    cmd = dsb_pkg::CMD_READ;
      3'd2:    cmd = dsb_pkg::CMD_PUSH;
      3'd3:    cmd = dsb_pkg::CMD_POP;
      3'd4:    cmd = dsb_pkg::CMD_START;
      3'd5:    cmd = dsb_pkg::CMD_STEP;
      default: cmd = dsb_pkg::CMD_NONE;
    endcase
  end

  assign in_ready   = !block && (count != 2'd2);
  assign push       = in_valid && in_ready;
  assign head_valid = (count != 2'd0);
  assign head       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{cmd: cmd, addr: addr, value: value};
    end
  end

endmodule

`default_nettype wire

[hdl/dsb_div.sv]
// ----------------------------------------------------------------------------
// dsb_div
// Iterative signed divider: one quotient bit per cycle on magnitudes, with
// truncating signs applied at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module dsb_div (
  input  wire logic      clk,
  input  wire logic      rst,
  input  dsb_pkg::div_req_t req,
  output dsb_pkg::div_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic        neg_q;
  logic        neg_r;
  logic [32:0] sh;
  logic [32:0] diff;

  assign sh   = {rem, quo[31]};
  assign diff = sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= 32'd0;
      quo   <= req.dividend[31] ? (32'd0 - req.dividend) : req.dividend;
      dvs   <= req.divisor[31] ? (32'd0 - req.divisor) : req.divisor;
      neg_q <= req.dividend[31] ^ req.divisor[31];
      neg_r <= req.dividend[31];
    end else if (busy) begin
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= sh[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = neg_q ? (32'd0 - quo) : quo;
  assign rsp.rem  = neg_r ? (32'd0 - rem) : rem;

endmodule

`default_nettype wire

[hdl/dsb_exec.sv]
// ----------------------------------------------------------------------------
// dsb_exec
// Execution back end: word memory, both stacks, the bundle sequencer and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dsb_exec #(
  parameter int MEM_WORDS  = 65536,
  parameter int DATA_DEPTH = 256,
  parameter int RET_DEPTH  = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  dsb_pkg::req_t      head,
  input  wire logic          head_valid,
  output logic               pop,
  output logic               clearing,
  input  wire logic          cfg_we,
  input  wire logic [5:0]    cfg_wdata,
  output dsb_pkg::div_req_t  dreq,
  input  dsb_pkg::div_rsp_t  drsp,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [2:0]         status,
  output logic [31:0]        read_value,
  output logic [16:0]        pc_now,
  output logic [7:0]         data_depth,
  output logic [7:0]         return_depth,
  output logic [4:0]         device_id
);

  localparam int AW   = $clog2(MEM_WORDS);
  localparam int DPW  = $clog2(DATA_DEPTH);
  localparam int RPW  = $clog2(RET_DEPTH);
  localparam int MAXD = (DATA_DEPTH > RET_DEPTH) ? DATA_DEPTH : RET_DEPTH;
  localparam int CW   = $clog2(MAXD);
  localparam logic [31:0] MEM32 = 32'(MEM_WORDS);

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_HOST  = 13'b0000000000100,
    S_HWAIT = 13'b0000000001000,
    S_RD    = 13'b0000000010000,
    S_EX    = 13'b0000000100000,
    S_MEM   = 13'b0000001000000,
    S_DIV   = 13'b0000010000000,
    S_WR1   = 13'b0000100000000,
    S_WR2   = 13'b0001000000000,
    S_NEXT  = 13'b0010000000000,
    S_FRD   = 13'b0100000000000,
    S_FOUT  = 13'b1000000000000
  } state_t;

  state_t state;
  dsb_pkg::req_t cur;

  logic [31:0] mem [MEM_WORDS];
  logic [31:0] ds  [DATA_DEPTH];
  logic [31:0] rs  [RET_DEPTH];

  logic [31:0] tt, nn, rr, mem_q;

  logic [DPW-1:0] dp;
  logic [RPW-1:0] rp;
  logic [31:0]    ip;
  logic [1:0]     slot;
  logic           paused;
  logic [31:0]    bundle;
  logic [2:0]     stat;
  logic [4:0]     dev;
  logic [31:0]    rv;
  logic           has_rv;
  logic [5:0]     devcnt;
  logic [2:0]     op_res;
  logic [CW-1:0]  clr_cnt;

  logic           we1, we2, rwe, mwe, mem_oor;
  logic [DPW-1:0] wa1, wa2;
  logic [31:0]    wd1, wd2, rwd, mwd;
  logic [RPW-1:0] rwa;
  logic [AW-1:0]  mwa;

  // Stack pointer neighbors.
  logic [DPW-1:0] dp_up, dp_nos, p1, p2;
  logic           stop1, stop2;
  logic [RPW-1:0] rp_up, rp_dn;
  logic [31:0]    ip_inc;
  logic [31:0]    bsel;
  logic [4:0]     opc;

  assign dp_up  = (dp == DPW'(DATA_DEPTH - 1)) ? '0 : dp + DPW'(1);
  assign dp_nos = (dp == '0) ? DPW'(DATA_DEPTH - 1) : dp - DPW'(1);
  assign stop1  = (dp == '0);
  assign p1     = stop1 ? '0 : dp_nos;
  assign stop2  = (p1 == '0);
  assign p2     = stop2 ? '0 : p1 - DPW'(1);
  assign rp_up  = (rp == RPW'(RET_DEPTH - 1)) ? '0 : rp + RPW'(1);
  assign rp_dn  = (rp == '0) ? rp : rp - RPW'(1);
  assign ip_inc = ip + 32'd1;
  assign bsel   = bundle >> {slot, 3'b000};
  assign opc    = bsel[4:0];

  function automatic logic bundle_bad(input logic [31:0] w);
    logic bad;
    bad = (w[7:0] > dsb_pkg::OPC_LAST) || (w[15:8] > dsb_pkg::OPC_LAST) ||
          (w[23:16] > dsb_pkg::OPC_LAST) || (w[31:24] > dsb_pkg::OPC_LAST);
    return bad;
  endfunction

  // A negative count shifts left, a positive count shifts right with sign fill.
  function automatic logic [31:0] shift_val(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] cnt;
    logic [31:0] res;
    if (y[31]) begin
      cnt = 32'd0 - y;
      res = (cnt >= 32'd32) ? 32'd0 : (x << cnt[4:0]);
    end else if (y >= 32'd32) begin
      res = x[31] ? 32'hFFFF_FFFF : 32'd0;
    end else begin
      res = 32'($signed(x) >>> y[4:0]);
    end
    return res;
  endfunction

  // Execute-stage decode.
  logic           x_we1, x_we2, x_rwe, x_mwe, x_mem, x_oor, x_div;
  logic [DPW-1:0] x_wa1, x_wa2, x_dp;
  logic [31:0]    x_wd1, x_wd2, x_rwd, x_mwd, x_ip, bv, prod, ipmid;
  logic [RPW-1:0] x_rwa, x_rp;
  logic [AW-1:0]  x_mwa;
  logic [2:0]     x_res;

  assign prod = nn * tt;

  always_comb begin
    case (opc)
      dsb_pkg::OPC_EQ:    bv = (nn == tt) ? 32'hFFFF_FFFF : 32'd0;
      dsb_pkg::OPC_NE:    bv = (nn != tt) ? 32'hFFFF_FFFF : 32'd0;
      dsb_pkg::OPC_LT:    bv = ($signed(nn) < $signed(tt)) ? 32'hFFFF_FFFF : 32'd0;
      dsb_pkg::OPC_GT:    bv = ($signed(nn) > $signed(tt)) ? 32'hFFFF_FFFF : 32'd0;
      dsb_pkg::OPC_ADD:   bv = nn + tt;
      dsb_pkg::OPC_SUB:   bv = nn - tt;
      dsb_pkg::OPC_MUL:   bv = prod;
      dsb_pkg::OPC_AND:   bv = nn & tt;
      dsb_pkg::OPC_OR:    bv = nn | tt;
      dsb_pkg::OPC_XOR:   bv = nn ^ tt;
      dsb_pkg::OPC_SHIFT: bv = shift_val(nn, tt);
      default:            bv = 32'd0;
    endcase
  end

  always_comb begin
    x_we1 = 1'b0; x_wa1 = dp; x_wd1 = 32'd0;
    x_we2 = 1'b0; x_wa2 = dp; x_wd2 = 32'd0;
    x_rwe = 1'b0; x_rwa = rp_up; x_rwd = ip;
    x_mwe = 1'b0; x_mwa = tt[AW-1:0]; x_mwd = nn;
    x_dp  = dp; x_rp = rp; x_ip = ip;
    x_res = dsb_pkg::ST_OK;
    x_mem = 1'b0; x_oor = 1'b0; x_div = 1'b0;
    ipmid = (stop1 || stop2) ? MEM32 : ip;
    case (opc)
      dsb_pkg::OPC_LIT: begin
        x_dp = dp_up; x_ip = ip_inc; x_mem = 1'b1;
        x_we1 = 1'b1; x_wa1 = dp_up; x_oor = (ip_inc >= MEM32);
      end
      dsb_pkg::OPC_DUP: begin
        x_dp = dp_up; x_we1 = 1'b1; x_wa1 = dp_up; x_wd1 = tt;
      end
      dsb_pkg::OPC_DROP: begin
        x_we1 = 1'b1; x_dp = p1;
        if (stop1) x_ip = MEM32;
      end
      dsb_pkg::OPC_SWAP: begin
        x_we1 = 1'b1; x_wd1 = nn;
        x_we2 = 1'b1; x_wa2 = dp_nos; x_wd2 = tt;
      end
      dsb_pkg::OPC_PUSH: begin
        x_rp = rp_up; x_rwe = 1'b1; x_rwd = tt;
        x_we1 = 1'b1; x_dp = p1;
        if (stop1) x_ip = MEM32;
      end
      dsb_pkg::OPC_POP: begin
        x_dp = dp_up; x_we1 = 1'b1; x_wa1 = dp_up; x_wd1 = rr; x_rp = rp_dn;
      end
      dsb_pkg::OPC_JUMP: begin
        x_we1 = 1'b1; x_dp = p1;
        x_ip = stop1 ? MEM32 : tt - 32'd1;
      end
      dsb_pkg::OPC_CALL: begin
        x_rp = rp_up; x_rwe = 1'b1; x_rwd = ip;
        x_we1 = 1'b1; x_dp = p1;
        x_ip = stop1 ? MEM32 : tt - 32'd1;
      end
      dsb_pkg::OPC_CCALL: begin
        // Both operands are dropped; the call is not taken when the
        // stack was already empty.
        x_we1 = 1'b1; x_we2 = 1'b1; x_wa2 = p1; x_dp = p2;
        if (!stop1 && nn != 32'd0) begin
          x_rp = rp_up; x_rwe = 1'b1; x_rwd = ipmid; x_ip = tt - 32'd1;
        end else begin
          x_ip = ipmid;
        end
      end
      dsb_pkg::OPC_RET: begin
        x_ip = rr; x_rp = rp_dn;
      end
      dsb_pkg::OPC_EQ, dsb_pkg::OPC_NE, dsb_pkg::OPC_LT, dsb_pkg::OPC_GT,
      dsb_pkg::OPC_ADD, dsb_pkg::OPC_SUB, dsb_pkg::OPC_MUL, dsb_pkg::OPC_AND,
      dsb_pkg::OPC_OR, dsb_pkg::OPC_XOR, dsb_pkg::OPC_SHIFT: begin
        x_we1 = 1'b1; x_wa1 = dp_nos; x_wd1 = bv;
        x_we2 = 1'b1; x_dp = p1;
        if (stop1) x_ip = MEM32;
      end
      dsb_pkg::OPC_FETCH: begin
        x_we1 = 1'b1;
        if (tt == 32'hFFFF_FFFF)      x_wd1 = 32'(dp) - 32'd1;
        else if (tt == 32'hFFFF_FFFE) x_wd1 = 32'(rp);
        else if (tt == 32'hFFFF_FFFD) x_wd1 = MEM32;
        else if (tt == 32'hFFFF_FFFC) x_wd1 = 32'h8000_0001;
        else if (tt == 32'hFFFF_FFFB) x_wd1 = 32'h7FFF_FFFE;
        else begin
          x_mem = 1'b1; x_oor = (tt >= MEM32);
        end
      end
      dsb_pkg::OPC_STORE: begin
        x_mwe = (tt < MEM32);
        x_we1 = 1'b1; x_we2 = 1'b1; x_wa2 = p1; x_dp = p2;
        if (stop1 || stop2) x_ip = MEM32;
      end
      dsb_pkg::OPC_DIV: begin
        if (tt == 32'd0) begin
          x_res = dsb_pkg::ST_DIVZ;
        end else begin
          x_div = 1'b1; x_we1 = 1'b1; x_we2 = 1'b1; x_wa2 = dp_nos;
        end
      end
      dsb_pkg::OPC_ZRET: begin
        if (tt == 32'd0) begin
          x_we1 = 1'b1; x_dp = p1; x_ip = rr; x_rp = rp_dn;
        end
      end
      dsb_pkg::OPC_HALT: begin
        x_ip = MEM32;
      end
      dsb_pkg::OPC_ENUM: begin
        x_dp = dp_up; x_we1 = 1'b1; x_wa1 = dp_up; x_wd1 = 32'(devcnt);
      end
      dsb_pkg::OPC_IOQ, dsb_pkg::OPC_IOI: begin
        x_we1 = 1'b1; x_dp = p1;
        if (stop1) x_ip = MEM32;
        x_res = (opc == dsb_pkg::OPC_IOQ) ? dsb_pkg::ST_IOQ : dsb_pkg::ST_IOI;
      end
      default: begin
      end
    endcase
  end

  assign dreq.start    = (state == S_EX) && x_div;
  assign dreq.dividend = nn;
  assign dreq.divisor  = tt;

  // Memory ports.
  logic           ds_we, rs_we, m_we;
  logic [DPW-1:0] ds_wa;
  logic [31:0]    ds_wd, rs_wd, m_wd;
  logic [RPW-1:0] rs_wa;
  logic [AW-1:0]  m_wa, m_ra;
  logic           host_in;
  logic           is_io;
  logic           fin_stop;
  logic           out_load;

  assign host_in  = (32'(cur.addr) < MEM32);
  assign is_io    = (op_res == dsb_pkg::ST_IOQ) || (op_res == dsb_pkg::ST_IOI);
  assign fin_stop = (rp == '0) || (ip_inc >= MEM32);
  assign out_load = (state == S_FOUT) && (!out_valid || out_ready);
  assign clearing = (state == S_CLEAR);
  assign pop      = (state == S_IDLE) && head_valid;

  always_comb begin
    ds_we = 1'b0; ds_wa = dp; ds_wd = 32'd0;
    rs_we = 1'b0; rs_wa = rwa; rs_wd = rwd;
    m_we  = 1'b0; m_wa = mwa; m_wd = mwd;
    case (state)
      S_CLEAR: begin
        ds_we = (32'(clr_cnt) < 32'(DATA_DEPTH)); ds_wa = clr_cnt[DPW-1:0];
        rs_we = (32'(clr_cnt) < 32'(RET_DEPTH));  rs_wa = clr_cnt[RPW-1:0];
        rs_wd = 32'd0;
      end
      S_HOST: begin
        if (cur.cmd == dsb_pkg::CMD_PUSH) begin
          ds_we = 1'b1; ds_wa = dp_up; ds_wd = cur.value;
        end
        if (cur.cmd == dsb_pkg::CMD_WRITE) begin
          m_we = host_in; m_wa = AW'(32'(cur.addr)); m_wd = cur.value;
        end
      end
      S_WR1: begin
        ds_we = we1; ds_wa = wa1; ds_wd = wd1;
        rs_we = rwe; m_we = mwe;
      end
      S_WR2: begin
        ds_we = we2; ds_wa = wa2; ds_wd = wd2;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (state == S_EX)
      m_ra = (opc == dsb_pkg::OPC_LIT) ? ip_inc[AW-1:0] : tt[AW-1:0];
    else if (state == S_HOST && cur.cmd == dsb_pkg::CMD_READ)
      m_ra = AW'(32'(cur.addr));
    else
      m_ra = ip[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (ds_we) ds[ds_wa] <= ds_wd;
    tt <= ds[dp];
    nn <= ds[dp_nos];
  end

  always_ff @(posedge clk) begin
    if (rs_we) rs[rs_wa] <= rs_wd;
    rr <= rs[rp];
  end

  always_ff @(posedge clk) begin
    if (m_we) mem[m_wa] <= m_wd;
    mem_q <= mem[m_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) devcnt <= 6'd0;
    else if (cfg_we) devcnt <= cfg_wdata;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      dp        <= '0;
      rp        <= '0;
      ip        <= MEM32;
      slot      <= 2'd0;
      paused    <= 1'b0;
      bundle    <= 32'd0;
      out_valid <= 1'b0;
      stat      <= dsb_pkg::ST_OK;
      dev       <= 5'd0;
      has_rv    <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + CW'(1);
          if (clr_cnt == CW'(MAXD - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (head_valid) begin
            cur   <= head;
            state <= S_HOST;
          end
        end
        S_HOST: begin
          stat   <= dsb_pkg::ST_OK;
          dev    <= 5'd0;
          has_rv <= 1'b0;
          state  <= S_FRD;
          case (cur.cmd)
            dsb_pkg::CMD_READ: state <= S_HWAIT;
            dsb_pkg::CMD_PUSH: dp <= dp_up;
            dsb_pkg::CMD_POP: begin
              rv     <= tt;
              has_rv <= 1'b1;
              if (dp != '0) dp <= dp - DPW'(1);
            end
            dsb_pkg::CMD_START: begin
              if (rp == '0) rp <= RPW'(1);
              ip     <= host_in ? 32'(cur.addr) : MEM32;
              paused <= 1'b0;
              slot   <= 2'd0;
              stat   <= host_in ? dsb_pkg::ST_OK : dsb_pkg::ST_HALT;
            end
            dsb_pkg::CMD_STEP: begin
              if (paused)            state <= S_RD;
              else if (ip >= MEM32)  stat  <= dsb_pkg::ST_HALT;
              else                   state <= S_HWAIT;
            end
            default: begin
            end
          endcase
        end
        S_HWAIT: begin
          state <= S_FRD;
          if (cur.cmd == dsb_pkg::CMD_READ) begin
            rv     <= host_in ? mem_q : 32'd0;
            has_rv <= 1'b1;
          end else begin
            bundle <= mem_q;
            slot   <= 2'd0;
            if (bundle_bad(mem_q)) begin
              stat <= dsb_pkg::ST_INVALID;
              ip   <= MEM32;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: state <= S_EX;
        S_EX: begin
          we1 <= x_we1; wa1 <= x_wa1; wd1 <= x_wd1;
          we2 <= x_we2; wa2 <= x_wa2; wd2 <= x_wd2;
          rwe <= x_rwe; rwa <= x_rwa; rwd <= x_rwd;
          mwe <= x_mwe; mwa <= x_mwa; mwd <= x_mwd;
          mem_oor <= x_oor;
          dp <= x_dp; rp <= x_rp; ip <= x_ip;
          op_res <= x_res;
          if (x_res == dsb_pkg::ST_IOQ || x_res == dsb_pkg::ST_IOI) dev <= tt[4:0];
          if (x_mem)      state <= S_MEM;
          else if (x_div) state <= S_DIV;
          else            state <= S_WR1;
        end
        S_MEM: begin
          wd1   <= mem_oor ? 32'd0 : mem_q;
          state <= S_WR1;
        end
        S_DIV: begin
          if (drsp.done) begin
            wd1   <= drsp.quot;
            wd2   <= drsp.rem;
            state <= S_WR1;
          end
        end
        S_WR1: state <= S_WR2;
        S_WR2: state <= S_NEXT;
        S_NEXT: begin
          if (op_res == dsb_pkg::ST_DIVZ) begin
            stat   <= dsb_pkg::ST_DIVZ;
            ip     <= MEM32;
            paused <= 1'b0;
            slot   <= 2'd0;
            state  <= S_FRD;
          end else if (is_io && slot != 2'd3) begin
            // Pause mid-bundle; the next step resumes at the following slot.
            stat   <= op_res;
            paused <= 1'b1;
            slot   <= slot + 2'd1;
            state  <= S_FRD;
          end else if (is_io || slot == 2'd3) begin
            ip     <= fin_stop ? MEM32 : ip_inc;
            paused <= 1'b0;
            slot   <= 2'd0;
            stat   <= is_io ? op_res : (fin_stop ? dsb_pkg::ST_HALT : stat);
            state  <= S_FRD;
          end else begin
            slot  <= slot + 2'd1;
            state <= S_RD;
          end
        end
        S_FRD: state <= S_FOUT;
        S_FOUT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic [31:0] dp32, rp32;
  assign dp32 = 32'(dp);
  assign rp32 = 32'(rp);

  always_ff @(posedge clk) begin
    if (out_load) begin
      status       <= stat;
      read_value   <= has_rv ? rv : tt;
      pc_now       <= (ip < MEM32) ? ip[16:0] : MEM32[16:0];
      data_depth   <= dp32[7:0];
      return_depth <= rp32[7:0];
      device_id    <= dev;
    end
  end

endmodule

`default_nettype wire

[hdl/dsb_checker.sv]
// ----------------------------------------------------------------------------
// dsb_checker
// Port-level checks for the dual-stack bundle processor core.
// ----------------------------------------------------------------------------
`default_nettype none

module dsb_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  status,
  input wire logic [31:0] read_value,
  input wire logic [4:0]  device_id
);

  // Reset starts the stack clearing pass, so nothing is taken or shown.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !in_ready && !out_valid)
    else $error("core not quiet after reset");

  // Only an I/O request names a device.
  a_dev_only_io: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != dsb_pkg::ST_IOQ && status != dsb_pkg::ST_IOI
      |-> device_id == 5'd0)
    else $error("device id set on a non-I/O result");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= dsb_pkg::ST_DIVZ)
    else $error("undefined status code");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(read_value))
    else $error("stalled result changed");

endmodule

bind dual_stack_bundle_cpu_top dsb_checker u_dsb_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .status     (status),
  .read_value (read_value),
  .device_id  (device_id)
);

`default_nettype wire
